// ===== src/sorted_table_gap_filler_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_table_gap_filler_defines
// assertion macros shared by the gap filler rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_GAP_FILLER_DEFINES_SVH
`define SORTED_TABLE_GAP_FILLER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define STGF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define STGF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/stgf_pkg.sv =====
// ----------------------------------------------------------------------------
// stgf_pkg
// sizes, codes and shared types of the sorted table gap filler
// ----------------------------------------------------------------------------
`default_nettype none

package stgf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_BITS  = 16;

    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 16;
    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [1:0]            t_status;
    typedef logic                  t_opcode;

    localparam t_opcode OP_INSERT = 1'b0;
    localparam t_opcode OP_NEXT   = 1'b1;

    localparam t_status ST_INSERTED = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMIT     = 2'd2;
    localparam t_status ST_END      = 2'd3;

    typedef struct packed {
        t_status               status;
        logic [OUT_BITS-1:0]   value;
    } t_res;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_val  wdata;
        t_idx  raddr;
    } t_mem_req;

    typedef struct packed {
        t_cnt  count;
        logic  idle;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/stgf_if.sv =====
// ----------------------------------------------------------------------------
// stgf_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface stgf_in_if;
    import stgf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [IN_BITS-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface stgf_out_if;
    import stgf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [OUT_BITS-1:0]  out_value;

    modport source (output valid, output status, output out_value, input ready);
    modport sink   (input valid, input status, input out_value, output ready);
endinterface

`default_nettype wire

// ===== src/stgf_ram.sv =====
// ----------------------------------------------------------------------------
// stgf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module stgf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/stgf_ctrl.sv =====
// ----------------------------------------------------------------------------
// stgf_ctrl
// command sequencer: insertion shift walk and gap-filled readout over the ram
// ----------------------------------------------------------------------------
`default_nettype none

module stgf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    stgf_in_if.sink                 i_in,
    output      stgf_pkg::t_res     o_res,
    output      logic               o_res_valid,
    input  wire logic               i_res_ready,
    output      stgf_pkg::t_mem_req o_mem_req,
    input  wire stgf_pkg::t_val     i_mem_rdata,
    output      stgf_pkg::t_stat    o_stat
);
    import stgf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIRST    = 3'd1;
    localparam logic [2:0] S_NEXT     = 3'd2;
    localparam logic [2:0] S_INS      = 3'd3;
    localparam logic [2:0] S_INS_LAST = 3'd4;
    localparam logic [2:0] S_POST     = 3'd5;

    logic [2:0] r_state, n_state;
    t_cnt       r_count, n_count;
    t_idx       r_ridx,  n_ridx;
    t_val       r_cur,   n_cur;
    logic       r_started, n_started;
    t_idx       r_k,     n_k;
    t_val       r_v,     n_v;
    t_res       r_res,   n_res;

    t_val       w_in_val;
    t_val       w_dec;
    logic       w_fire;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_fire     = i_in.valid && (r_state == S_IDLE);
    assign w_in_val   = VALUE_BITS'(i_in.value);
    assign w_dec      = r_cur - t_val'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ridx    = r_ridx;
        n_cur     = r_cur;
        n_started = r_started;
        n_k       = r_k;
        n_v       = r_v;
        n_res     = r_res;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_k;
        o_mem_req.wdata = r_v;
        o_mem_req.raddr = r_ridx;
        o_res_valid     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    if (i_in.opcode == OP_INSERT) begin
                        if (r_count == CNT_W'(TABLE_DEPTH)) begin
                            n_res   = '{status: ST_FULL, value: '0};
                            n_state = S_POST;
                        end else begin
                            n_v       = w_in_val;
                            n_started = 1'b0;
                            n_ridx    = '0;
                            n_cur     = '0;
                            n_count   = r_count + t_cnt'(1);
                            if (r_count == '0) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = '0;
                                o_mem_req.wdata = w_in_val;
                                n_res   = '{status: ST_INSERTED, value: '0};
                                n_state = S_POST;
                            end else begin
                                n_k             = IDX_W'(r_count);
                                o_mem_req.raddr = IDX_W'(r_count - t_cnt'(1));
                                n_state         = S_INS;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res   = '{status: ST_END, value: '0};
                            n_state = S_POST;
                        end else if (!r_started) begin
                            o_mem_req.raddr = '0;
                            n_state         = S_FIRST;
                        end else if (CNT_W'(r_ridx) + t_cnt'(1) >= r_count) begin
                            n_res   = '{status: ST_END, value: '0};
                            n_state = S_POST;
                        end else begin
                            o_mem_req.raddr = r_ridx + t_idx'(1);
                            n_state         = S_NEXT;
                        end
                    end
                end
            end
            S_FIRST: begin
                n_started = 1'b1;
                n_ridx    = '0;
                n_cur     = i_mem_rdata;
                n_res     = '{status: ST_EMIT, value: OUT_BITS'(i_mem_rdata)};
                n_state   = S_POST;
            end
            S_NEXT: begin
                if (i_mem_rdata == r_cur) begin
                    n_ridx = r_ridx + t_idx'(1);
                    n_res  = '{status: ST_EMIT, value: OUT_BITS'(r_cur)};
                end else begin
                    n_cur = w_dec;
                    if (w_dec == i_mem_rdata) begin
                        n_ridx = r_ridx + t_idx'(1);
                    end
                    n_res = '{status: ST_EMIT, value: OUT_BITS'(w_dec)};
                end
                n_state = S_POST;
            end
            S_INS: begin
                // data is the entry just above slot r_k
                o_mem_req.we = 1'b1;
                if (i_mem_rdata > r_v) begin
                    o_mem_req.wdata = r_v;
                    n_res   = '{status: ST_INSERTED, value: '0};
                    n_state = S_POST;
                end else begin
                    o_mem_req.wdata = i_mem_rdata;
                    n_k             = r_k - t_idx'(1);
                    if (r_k == t_idx'(1)) begin
                        n_state = S_INS_LAST;
                    end else begin
                        o_mem_req.raddr = r_k - t_idx'(2);
                    end
                end
            end
            S_INS_LAST: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = r_v;
                n_res   = '{status: ST_INSERTED, value: '0};
                n_state = S_POST;
            end
            S_POST: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ridx    <= '0;
            r_cur     <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ridx    <= n_ridx;
            r_cur     <= n_cur;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_v   <= n_v;
        r_res <= n_res;
    end

    assign o_res        = r_res;
    assign o_stat.count = r_count;
    assign o_stat.idle  = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== src/stgf_out.sv =====
// ----------------------------------------------------------------------------
// stgf_out
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module stgf_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire stgf_pkg::t_res i_res,
    input  wire logic           i_res_valid,
    output      logic           o_res_ready,
    stgf_out_if.source          o_out
);
    import stgf_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_res_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.status    = r_res.status;
    assign o_out.out_value = r_res.value;

endmodule

`default_nettype wire

// ===== src/sorted_table_gap_filler.sv =====
// next beat: read state, post state, then the output register; with no table read, straight to post
// insert beat: shift walk over the entries moved, then post; into an empty or full table straight to post
// one command at a time: a new beat is taken only while the sequencer is idle
// the shift walk is bound by the single read and single write port of the table ram
// reset: synchronous active low, clears count and readout state; ram contents stay
// undefined and are never read at or above the count, so no clearing pass is needed
// ----------------------------------------------------------------------------
// sorted_table_gap_filler
// descending sorted table with gap-filled readout, top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_gap_filler_defines.svh"

module sorted_table_gap_filler (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    stgf_in_if.sink     i_in,
    stgf_out_if.source  o_out
);
    import stgf_pkg::*;

    t_res     w_res;
    logic     w_res_valid;
    logic     w_res_ready;
    t_mem_req w_mem_req;
    t_val     w_mem_rdata;
    t_stat    w_stat;
    logic     w_in_fire;
    logic     w_full_ins;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_full_ins = w_in_fire && (i_in.opcode == OP_INSERT) &&
                        (w_stat.count == CNT_W'(TABLE_DEPTH));

    stgf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_req.we),
        .i_waddr (w_mem_req.waddr),
        .i_wdata (w_mem_req.wdata),
        .i_raddr (w_mem_req.raddr),
        .o_rdata (w_mem_rdata)
    );

    stgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata),
        .o_stat      (w_stat)
    );

    stgf_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .i_res_valid (w_res_valid),
        .o_res_ready (w_res_ready),
        .o_out       (o_out)
    );

    `STGF_ASSERT_NEXT(a_busy_after_beat, w_in_fire, !w_stat.idle, "sequencer idle after a beat")
    `STGF_ASSERT_SAME(a_count_bound, 1'b1, w_stat.count <= CNT_W'(TABLE_DEPTH), "count overflow")
    `STGF_ASSERT_NEXT(a_full_keeps_count, w_full_ins, $stable(w_stat.count), "full insert moved count")
    `STGF_ASSERT_SAME(a_no_post_when_idle, w_stat.idle, !w_res_valid, "result posted while idle")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted table gap filler: a predictor class keeps
// its own copy of the table and readout state, every command beat is predicted
// on acceptance and every result beat is checked in order. values cluster
// around the top-bit boundary so readouts run to their end and toggle every bit
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import stgf_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int ROUNDS_PER_PHASE = 18;

    class gap_fill_predictor;
        t_val   tbl [TABLE_DEPTH];
        int     count;
        int     rd_idx;
        t_val   cur;
        bit     started;
        t_res   expected_results [$];
        int     errors;

        function new();
            count   = 0;
            rd_idx  = 0;
            cur     = '0;
            started = 1'b0;
            errors  = 0;
        endfunction

        function void note_command(t_opcode op, t_val v);
            t_res r;
            t_val nxt;
            int   pos;
            int   k;
            r.status = ST_END;
            r.value  = '0;
            if (op == OP_INSERT) begin
                if (count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < count && v < tbl[pos])
                        pos++;
                    for (k = count; k > pos; k--)
                        tbl[k] = tbl[k-1];
                    tbl[pos] = v;
                    count++;
                    started  = 1'b0;
                    rd_idx   = 0;
                    cur      = '0;
                    r.status = ST_INSERTED;
                end
            end else if (count == 0) begin
                r.status = ST_END;
            end else if (!started) begin
                started  = 1'b1;
                rd_idx   = 0;
                cur      = tbl[0];
                r.status = ST_EMIT;
                r.value  = cur;
            end else if (rd_idx + 1 >= count || rd_idx + 1 >= TABLE_DEPTH) begin
                r.status = ST_END;
            end else begin
                nxt = tbl[rd_idx+1];
                if (nxt == cur) begin
                    rd_idx++;
                end else begin
                    cur = cur - 1'b1;
                    if (cur == nxt)
                        rd_idx++;
                end
                r.status = ST_EMIT;
                r.value  = cur;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(t_status status, logic [OUT_BITS-1:0] value);
            t_res e;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: status %0d out_value %0d", status, value);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (status !== e.status) begin
                    $error("status mismatch: expected %0d actual %0d", e.status, status);
                    errors++;
                end
                if (value !== e.value) begin
                    $error("out_value mismatch: expected %0d actual %0d", e.value, value);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    stgf_in_if  in_ch ();
    stgf_out_if out_ch ();

    sorted_table_gap_filler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gap_fill_predictor sb = new();

    int src_idle_pct = 16;
    int rx_idle_pct  = 49;
    int rx_hold      = 0;
    int idle_cycles  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_INSERT;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    // result side: ready decided at the falling edge, beats checked at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.status, out_ch.out_value);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(input t_opcode op, input t_val val);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= val;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        sb.note_command(op, val);
        @(negedge i_clk);
    endtask

    task automatic send_next();
        send_cmd(OP_NEXT, t_val'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() > 0)
            @(negedge i_clk);
    endtask

    // insert one value near the top-bit boundary, then read part or all of the sequence
    task automatic run_round(input bit long_hold);
        int n;
        int i;
        n = $urandom_range(0, 55);
        send_cmd(OP_INSERT, t_val'(32'h8000 - 20 + $urandom_range(0, 40)));
        if (long_hold)
            rx_hold = 300;
        for (i = 0; i < n; i++)
            send_next();
    endtask

    initial begin
        int p;
        int r;
        int i;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, single entry, duplicates, gaps, restart mid readout
        send_next();
        send_cmd(OP_NEXT, 16'hFFFF);
        send_cmd(OP_INSERT, 16'h8000);
        send_cmd(OP_NEXT, 16'h0000);
        send_next();
        send_next();
        send_cmd(OP_INSERT, 16'h8000);
        send_cmd(OP_INSERT, 16'h7FFD);
        send_cmd(OP_INSERT, 16'h8002);
        for (i = 0; i < 8; i++)
            send_next();
        send_cmd(OP_INSERT, 16'h7FFF);
        send_next();
        send_next();
        send_cmd(OP_INSERT, 16'h8001);
        for (i = 0; i < 4; i++)
            send_next();

        for (p = 0; p < 3; p++) begin
            drain();
            case (p)
                0: begin
                    src_idle_pct = 16;
                    rx_idle_pct  = 49;
                end
                1: begin
                    src_idle_pct = 49;
                    rx_idle_pct  = 16;
                end
                default: begin
                    src_idle_pct = 0;
                    rx_idle_pct  = 0;
                end
            endcase
            for (r = 0; r < ROUNDS_PER_PHASE; r++)
                run_round(p == 0 && r == 5);
        end

        // extremes into the table, then fill it and keep pushing
        send_cmd(OP_INSERT, 16'hFFFF);
        for (i = 0; i < 10; i++)
            send_next();
        send_cmd(OP_INSERT, 16'h0000);
        for (i = 0; i < 5; i++)
            send_next();
        send_cmd(OP_INSERT, t_val'($urandom));
        send_cmd(OP_INSERT, t_val'($urandom));
        send_cmd(OP_INSERT, 16'h0000);
        send_next();
        send_cmd(OP_INSERT, 16'hFFFF);
        for (i = 0; i < 6; i++) begin
            send_cmd(OP_INSERT, t_val'($urandom));
            send_next();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            if (sb.pending() != 0)
                $error("%0d expected results never arrived", sb.pending());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
